/* hw/rtl/uvb_pkg.sv */
// Shared types and constants for the unordered value bag.
package uvb_pkg;

  // Default number of entries in the store.
  localparam int CAPACITY_DEFAULT = 16;

  // Item field widths.
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 2;
  localparam int FILL_W      = 5;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Action codes carried in the low bits of the input beat.
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic write;  // store the insert value in the cell at the fill position
    logic load;   // capture hole and tally flags against the search key
    logic step;   // one compaction round and one tally shift
    logic phase;  // parity of the cell pairs that may swap in this round
  } cell_ctl_t;

endpackage

/* hw/rtl/uvb_cell.sv */
// One storage cell of the bag: an entry, its compare logic and its swap rules.
module uvb_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  uvb_pkg::cell_ctl_t        ctl,
  input  logic [CW-1:0]             count,
  input  logic [uvb_pkg::DATA_W-1:0] key,
  input  logic [uvb_pkg::DATA_W-1:0] wr_data,
  input  logic [uvb_pkg::DATA_W-1:0] left_data,
  input  logic                      left_hole,
  input  logic [uvb_pkg::DATA_W-1:0] right_data,
  input  logic                      right_hole,
  input  logic                      right_tally,
  output logic [uvb_pkg::DATA_W-1:0] data,
  output logic                      hole,
  output logic                      tally
);
  import uvb_pkg::*;

  localparam logic PAR = 1'(INDEX % 2);

  logic in_range;
  logic hit;
  logic left_role;
  logic take_right;
  logic take_left;

  // Compare against the key and decide this cell's part in the current round.
  always_comb begin
    in_range   = CW'(INDEX) < count;
    hit        = data == key;
    left_role  = ctl.phase == PAR;
    take_right = left_role && hole && !right_hole;
    take_left  = !left_role && left_hole && !hole;
  end

  // Entry payload: written by insert, moved by compaction swaps.
  always_ff @(posedge clk) begin
    if (ctl.write && count == CW'(INDEX)) begin
      data <= wr_data;
    end else if (ctl.step && take_right) begin
      data <= right_data;
    end else if (ctl.step && take_left) begin
      data <= left_data;
    end
  end

  // Hole marks entries to squeeze out; tally carries in-range hits toward cell zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      hole  <= 1'b0;
      tally <= 1'b0;
    end else if (ctl.load) begin
      hole  <= !in_range || hit;
      tally <= in_range && hit;
    end else if (ctl.step) begin
      tally <= right_tally;
      if (take_right) begin
        hole <= 1'b0;
      end else if (take_left) begin
        hole <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/unordered_value_bag.sv */
// Insert, clear: from idle straight to the done state; the result beat is registered there
// once the output is free. Remove, contains: a load state, then one compaction round and
// one tally shift per stored entry in the cell chain, then the done state; a new beat is
// taken once the result is registered.
// One item is in work at a time; the result register lets the next beat in while it waits.
// Reset empties the bag (fill count zero); the entry cells are not cleared and need no sweep.
module unordered_value_bag #(
  parameter int CAPACITY = uvb_pkg::CAPACITY_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: action [1:0], value [33:2], zero fill [39:34]
  input  logic [uvb_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: found [0], is_empty [1], fill_count [6:2], insert_dropped [7]
  output logic [uvb_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import uvb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t              state, state_next;
  action_t             act;
  logic [DATA_W-1:0]   key;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       steps;
  logic [CW-1:0]       hit_total;
  logic                phase;
  logic                found_acc;
  logic                emit;
  logic                full;
  logic                found_next;
  logic                dropped_next;
  cell_ctl_t           ctl;

  logic [DATA_W-1:0]   cell_data  [CAPACITY];
  logic                cell_hole  [CAPACITY];
  logic                cell_tally [CAPACITY];

  assign s_tready = state == ST_IDLE;
  assign emit     = state == ST_DONE && (!m_tvalid || m_tready);
  assign full     = count == CW'(CAPACITY);

  // Broadcast control for the chain.
  always_comb begin
    ctl.write = emit && act == ACT_INSERT && !full;
    ctl.load  = state == ST_LOAD;
    ctl.step  = state == ST_SCAN;
    ctl.phase = phase;
  end

  // Row of cells, each linked to its left and right neighbor where one exists.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] l_data, r_data;
    logic              l_hole, r_hole, r_tally;

    if (i == 0) begin : g_first
      assign l_data = '0;
      assign l_hole = 1'b0;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_hole = cell_hole[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_data  = '0;
      assign r_hole  = 1'b1;
      assign r_tally = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_hole  = cell_hole[i+1];
      assign r_tally = cell_tally[i+1];
    end

    uvb_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .count       (count),
      .key         (key),
      .wr_data     (key),
      .left_data   (l_data),
      .left_hole   (l_hole),
      .right_data  (r_data),
      .right_hole  (r_hole),
      .right_tally (r_tally),
      .data        (cell_data[i]),
      .hole        (cell_hole[i]),
      .tally       (cell_tally[i])
    );
  end

  // Sequencer transitions.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (action_t'(s_tdata[ACT_W-1:0]) == ACT_REMOVE ||
              action_t'(s_tdata[ACT_W-1:0]) == ACT_CONTAINS) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LOAD: begin
        state_next = (count == '0) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (steps == CW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result of the finished item.
  always_comb begin
    count_next   = count;
    found_next   = 1'b0;
    dropped_next = 1'b0;
    unique case (act)
      ACT_INSERT: begin
        if (full) begin
          dropped_next = 1'b1;
        end else begin
          count_next = count + CW'(1);
        end
      end
      ACT_REMOVE:   count_next = count - hit_total;
      ACT_CONTAINS: found_next = found_acc;
      ACT_CLEAR:    count_next = '0;
      default:      count_next = count;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Item capture, scan counters and result beat.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act <= action_t'(s_tdata[ACT_W-1:0]);
      key <= s_tdata[ACT_W +: DATA_W];
    end
    if (state == ST_LOAD) begin
      steps     <= count;
      hit_total <= '0;
      found_acc <= 1'b0;
      phase     <= 1'b0;
    end else if (state == ST_SCAN) begin
      steps     <= steps - CW'(1);
      hit_total <= hit_total + CW'(cell_tally[0]);
      found_acc <= found_acc | cell_tally[0];
      phase     <= !phase;
    end
    if (emit) begin
      m_tdata <= {dropped_next, FILL_W'(count_next), count_next == '0, found_next};
    end
  end

endmodule

/* tb/uvb_result_checker.sv */
// Result checker for the unordered value bag: tracks the bag contents and checks every result.
`timescale 1ns / 100ps

module uvb_result_checker #(
  parameter int CAPACITY = uvb_pkg::CAPACITY_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // s_tdata: action [1:0], value [33:2], zero fill [39:34]
  input  logic [uvb_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: found [0], is_empty [1], fill_count [6:2], insert_dropped [7]
  input  logic [uvb_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                              mismatch_count,
  output int                              pending_count
);
  import uvb_pkg::*;

  localparam int MAX_REPORTS = 10;

  // One result beat, split into its fields.
  typedef struct packed {
    logic              found;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
    logic              insert_dropped;
  } bag_status_t;

  // Shadow copy of the bag: packed entries and the fill count.
  logic [DATA_W-1:0] bag_vals [CAPACITY];
  int                bag_fill;

  // Status beats owed by the block, oldest first.
  bag_status_t expected_status [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    bag_fill       = 0;
  end

  // Apply one action to the shadow bag and return the status it should report.
  function automatic bag_status_t apply_bag_action(action_t act, logic [DATA_W-1:0] val);
    bag_status_t res;
    int          kept;
    res  = '0;
    kept = 0;
    case (act)
      ACT_INSERT: begin
        if (bag_fill < CAPACITY) begin
          bag_vals[bag_fill] = val;
          bag_fill++;
        end else begin
          res.insert_dropped = 1'b1;
        end
      end
      ACT_REMOVE: begin
        // Compact the survivors toward the front, keeping their order.
        for (int i = 0; i < bag_fill; i++) begin
          if (bag_vals[i] != val) begin
            bag_vals[kept] = bag_vals[i];
            kept++;
          end
        end
        bag_fill = kept;
      end
      ACT_CONTAINS: begin
        for (int i = 0; i < bag_fill; i++) begin
          if (bag_vals[i] == val) res.found = 1'b1;
        end
      end
      default: begin
        // Clear leaves stale words behind; only the count drops.
        bag_fill = 0;
      end
    endcase
    res.is_empty   = (bag_fill == 0);
    res.fill_count = FILL_W'(bag_fill);
    return res;
  endfunction

  // Compare each result beat first, then predict from the input beat of the same edge.
  always @(posedge clk) begin
    bag_status_t seen;
    bag_status_t want;
    if (rst) begin
      bag_fill = 0;
      expected_status.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.found          = m_tdata[0];
        seen.is_empty       = m_tdata[1];
        seen.fill_count     = m_tdata[6:2];
        seen.insert_dropped = m_tdata[7];
        if (expected_status.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: unexpected result beat, m_tdata=%h", $realtime, m_tdata);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          if (seen.found !== want.found || seen.is_empty !== want.is_empty ||
              seen.fill_count !== want.fill_count ||
              seen.insert_dropped !== want.insert_dropped) begin
            if (mismatch_count < MAX_REPORTS)
              $display({"%0t: result mismatch: expected found=%0b empty=%0b count=%0d ",
                        "dropped=%0b, got found=%0b empty=%0b count=%0d dropped=%0b"},
                       $realtime, want.found, want.is_empty, want.fill_count,
                       want.insert_dropped, seen.found, seen.is_empty, seen.fill_count,
                       seen.insert_dropped);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_status.push_back(apply_bag_action(action_t'(s_tdata[ACT_W-1:0]),
                                                   s_tdata[ACT_W+DATA_W-1:ACT_W]));
    end
    pending_count = expected_status.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the unordered value bag testbench: clock, reset, stimulus, ready pattern and verdict.
`timescale 1ns / 100ps

module tb_top;
  import uvb_pkg::*;

  localparam int RX_HOLD_CYCLES = 200;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PAD_W          = IN_TDATA_W - ACT_W - DATA_W;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatch_count;
  int pending_count;

  // Idle percentages for each side, changed between phases.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // Long receiver hold-off requests and their service count.
  int rx_hold_asks = 0;
  int rx_hold_done = 0;
  int rx_hold_left = 0;

  int idle_cycles = 0;

  // Values chosen often so that removes and lookups hit stored entries.
  logic [DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                                        32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                                        32'h5555_5555, 32'hAAAA_AAAA};

  unordered_value_bag dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  uvb_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random ready, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_done != rx_hold_asks) begin
      m_tready     <= 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_done <= rx_hold_done + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: too many cycles in a row without any beat on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and wait for the handshake.
  task automatic send_item(input action_t act, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{PAD_W{1'b0}}, val, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the input quiet until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Random items in stretches that favor filling, draining or a mix.
  task automatic send_random(input int n_items);
    int                mode;
    int                r;
    action_t           act;
    logic [DATA_W-1:0] val;
    mode = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) mode = $urandom_range(2);
      r = $urandom_range(99);
      case (mode)
        0:       act = (r < 70) ? ACT_INSERT : (r < 82) ? ACT_REMOVE :
                       (r < 97) ? ACT_CONTAINS : ACT_CLEAR;
        1:       act = (r < 25) ? ACT_INSERT : (r < 60) ? ACT_REMOVE :
                       (r < 97) ? ACT_CONTAINS : ACT_CLEAR;
        default: act = (r < 45) ? ACT_INSERT : (r < 65) ? ACT_REMOVE :
                       (r < 95) ? ACT_CONTAINS : ACT_CLEAR;
      endcase
      val = ($urandom_range(3) == 0) ? DATA_W'($urandom) : value_pool[$urandom_range(7)];
      send_item(act, val);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty bag, extreme values, duplicates, misses, clear with stale entries.
    tx_idle_pct = 33;
    rx_idle_pct = 63;
    send_item(ACT_CONTAINS, 32'h0000_0000);
    send_item(ACT_REMOVE,   32'h0000_0000);
    send_item(ACT_INSERT,   32'h8000_0000);
    send_item(ACT_INSERT,   32'h7FFF_FFFF);
    send_item(ACT_INSERT,   32'hFFFF_FFFF);
    send_item(ACT_INSERT,   32'h0000_0000);
    send_item(ACT_INSERT,   32'h0000_0007);
    send_item(ACT_INSERT,   32'hFFFF_FFFF);
    send_item(ACT_CONTAINS, 32'h8000_0000);
    send_item(ACT_CONTAINS, 32'h0000_1234);
    send_item(ACT_REMOVE,   32'hFFFF_FFFF);
    send_item(ACT_CONTAINS, 32'hFFFF_FFFF);
    send_item(ACT_REMOVE,   32'h0000_0063);
    send_item(ACT_CLEAR,    32'h0000_0000);
    send_item(ACT_CONTAINS, 32'h0000_0007);
    send_item(ACT_INSERT,   32'h0000_0007);
    send_item(ACT_REMOVE,   32'h0000_0007);

    send_random(560);
    wait_drained();

    // Receiver stalls for a long stretch while the sender keeps pushing inserts, with a lookup every eighth item.
    tx_idle_pct  = 0;
    rx_hold_asks = rx_hold_asks + 1;
    for (int i = 0; i < 40; i++)
      send_item((i % 8 == 7) ? ACT_CONTAINS : ACT_INSERT, value_pool[$urandom_range(7)]);
    wait_drained();

    tx_idle_pct = 63;
    rx_idle_pct = 33;
    send_random(560);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(560);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/uvb_pkg.sv
hw/rtl/uvb_cell.sv
hw/rtl/unordered_value_bag.sv
tb/uvb_result_checker.sv
tb/tb_top.sv
